/* rtl/bcu_pkg.sv */
// Shared constants for the barycentric coordinates unit.
// No dependencies.
package bcu_pkg;
    localparam int OW          = 32;          // result weight width
    localparam int QB          = OW + 1;      // quotient bits produced by the divider
    localparam int MUL_STAGES  = 3;
    localparam int CRS_STAGES  = MUL_STAGES + 1;
    localparam int DOT_STAGES  = MUL_STAGES + 1;
    localparam int DIV_STAGES  = QB + 3;
    localparam logic signed [OW-1:0] W_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] W_MIN = {1'b1, {(OW-1){1'b0}}};
endpackage

/* rtl/bcu_in_if.sv */
// Input channel: query point and triangle corners, valid/ready.
// Depends on nothing.
interface bcu_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] p_x, p_y, p_z;
    logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z;
    logic signed [COORD_WIDTH-1:0] b_x, b_y, b_z;
    logic signed [COORD_WIDTH-1:0] c_x, c_y, c_z;
    modport src (output valid, p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z,
                 c_x, c_y, c_z, input ready);
    modport snk (input valid, p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z,
                 c_x, c_y, c_z, output ready);
endinterface

/* rtl/bcu_out_if.sv */
// Output channel: barycentric weights and degenerate flag, valid/ready.
// Depends on nothing.
interface bcu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] weight_a;
    logic signed [31:0] weight_b;
    logic signed [31:0] weight_c;
    logic               degenerate;
    modport src (output valid, weight_a, weight_b, weight_c, degenerate, input ready);
    modport snk (input valid, weight_a, weight_b, weight_c, degenerate, output ready);
endinterface

/* rtl/bcu_mul.sv */
// Three-stage signed multiplier built from four half-width partial products.
// Uses bcu_pkg.
module bcu_mul #(
    parameter int W = 33
) (
    input  logic                              i_clk,
    input  logic [bcu_pkg::MUL_STAGES-1:0]    i_en,
    input  logic signed [W-1:0]               i_a,
    input  logic signed [W-1:0]               i_b,
    output logic signed [2*W-1:0]             o_p
);
    import bcu_pkg::*;
    localparam int H = (W + 1) / 2;
    localparam int G = W - H;

    logic [W-1:0]     r_ma, r_mb;
    logic             r_neg0, r_neg1;
    logic [2*H-1:0]   r_ll;
    logic [H+G-1:0]   r_lh, r_hl;
    logic [2*G-1:0]   r_hh;
    logic [2*W-1:0]   n_sum;

    // magnitudes; the most negative value maps to 2^(W-1) correctly
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ma   <= i_a[W-1] ? (~i_a + 1'b1) : i_a;
            r_mb   <= i_b[W-1] ? (~i_b + 1'b1) : i_b;
            r_neg0 <= i_a[W-1] ^ i_b[W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_ll   <= r_ma[H-1:0] * r_mb[H-1:0];
            r_lh   <= r_ma[H-1:0] * r_mb[W-1:H];
            r_hl   <= r_ma[W-1:H] * r_mb[H-1:0];
            r_hh   <= r_ma[W-1:H] * r_mb[W-1:H];
            r_neg1 <= r_neg0;
        end
    end

    always_comb begin
        n_sum = (2*W)'(r_ll) + ((2*W)'(r_lh) << H) + ((2*W)'(r_hl) << H)
              + ((2*W)'(r_hh) << (2*H));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_p <= r_neg1 ? (~n_sum + 1'b1) : n_sum;
        end
    end
endmodule

/* rtl/bcu_crs.sv */
// Pipelined 3D cross product: six multipliers, then one subtract stage.
// Uses bcu_pkg and bcu_mul.
module bcu_crs #(
    parameter int DW = 33
) (
    input  logic                              i_clk,
    input  logic [bcu_pkg::CRS_STAGES-1:0]    i_en,
    input  logic signed [DW-1:0]              i_u [3],
    input  logic signed [DW-1:0]              i_v [3],
    output logic signed [2*DW:0]              o_r [3]
);
    import bcu_pkg::*;

    logic signed [2*DW-1:0] w_pp [3];
    logic signed [2*DW-1:0] w_pm [3];

    for (genvar k = 0; k < 3; k++) begin : g_axis
        localparam int J1 = (k + 1) % 3;
        localparam int J2 = (k + 2) % 3;
        bcu_mul #(.W(DW)) u_mp (
            .i_clk (i_clk), .i_en (i_en[MUL_STAGES-1:0]),
            .i_a (i_u[J1]), .i_b (i_v[J2]), .o_p (w_pp[k])
        );
        bcu_mul #(.W(DW)) u_mm (
            .i_clk (i_clk), .i_en (i_en[MUL_STAGES-1:0]),
            .i_a (i_u[J2]), .i_b (i_v[J1]), .o_p (w_pm[k])
        );
        always_ff @(posedge i_clk) begin
            if (i_en[MUL_STAGES]) begin
                o_r[k] <= (2*DW+1)'(w_pp[k]) - (2*DW+1)'(w_pm[k]);
            end
        end
    end
endmodule

/* rtl/bcu_dot.sv */
// Pipelined 3D dot product: three multipliers, then one sum stage.
// Uses bcu_pkg and bcu_mul.
module bcu_dot #(
    parameter int NW = 67
) (
    input  logic                              i_clk,
    input  logic [bcu_pkg::DOT_STAGES-1:0]    i_en,
    input  logic signed [NW-1:0]              i_u [3],
    input  logic signed [NW-1:0]              i_v [3],
    output logic signed [2*NW+1:0]            o_s
);
    import bcu_pkg::*;

    logic signed [2*NW-1:0] w_p [3];

    for (genvar k = 0; k < 3; k++) begin : g_term
        bcu_mul #(.W(NW)) u_mul (
            .i_clk (i_clk), .i_en (i_en[MUL_STAGES-1:0]),
            .i_a (i_u[k]), .i_b (i_v[k]), .o_p (w_p[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en[MUL_STAGES]) begin
            o_s <= (2*NW+2)'(w_p[0]) + (2*NW+2)'(w_p[1]) + (2*NW+2)'(w_p[2]);
        end
    end
endmodule

/* rtl/bcu_div.sv */
// Pipelined restoring divider: rounded, saturated num * 2^F / den, one
// quotient bit per stage. Uses bcu_pkg.
module bcu_div #(
    parameter int SW        = 136,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic [bcu_pkg::DIV_STAGES-1:0]    i_en,
    input  logic signed [SW-1:0]              i_num,
    input  logic signed [SW-1:0]              i_den,
    output logic signed [bcu_pkg::OW-1:0]     o_w,
    output logic                              o_dz
);
    import bcu_pkg::*;
    localparam int RW = SW + FRAC_BITS + 36;

    logic [SW-1:0] w_mag;
    logic [RW-1:0] r_x, r_d0;
    logic          r_neg0, r_dz0;
    logic [RW-1:0] r_rem [QB+1];
    logic [RW-1:0] r_dd  [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_neg [QB+1];
    logic          r_ovf [QB+1];
    logic          r_dz  [QB+1];
    logic [QB-1:0] w_q;

    assign w_mag = i_num[SW-1] ? (~i_num + 1'b1) : i_num;

    // X = 2*|num|*2^F + den, D = 2*den: floor(X/D) is the rounded quotient
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x    <= (RW'(w_mag) << (FRAC_BITS + 1)) + RW'($unsigned(i_den));
            r_d0   <= RW'($unsigned(i_den)) << 1;
            r_neg0 <= i_num[SW-1];
            r_dz0  <= (i_den == '0);
        end
    end

    // quotient beyond QB bits saturates anyway
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rem[0] <= r_x;
            r_dd[0]  <= r_d0;
            r_q[0]   <= '0;
            r_neg[0] <= r_neg0;
            r_ovf[0] <= (r_x >= (r_d0 << QB));
            r_dz[0]  <= r_dz0;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int SH = QB - 1 - j;
        logic [RW-1:0] w_sd;
        logic          w_ge;
        assign w_sd = r_dd[j] << SH;
        assign w_ge = (r_rem[j] >= w_sd);
        always_ff @(posedge i_clk) begin
            if (i_en[2+j]) begin
                r_rem[j+1]   <= w_ge ? (r_rem[j] - w_sd) : r_rem[j];
                r_q[j+1]     <= r_q[j] | (QB'(w_ge) << SH);
                r_dd[j+1]    <= r_dd[j];
                r_neg[j+1]   <= r_neg[j];
                r_ovf[j+1]   <= r_ovf[j];
                r_dz[j+1]    <= r_dz[j];
            end
        end
    end

    assign w_q = r_q[QB];

    always_ff @(posedge i_clk) begin
        if (i_en[QB+2]) begin
            o_dz <= r_dz[QB];
            if (r_neg[QB]) begin
                if (r_ovf[QB] || (w_q > (QB'(1) << (OW-1)))) o_w <= W_MIN;
                else                                          o_w <= OW'(~w_q + 1'b1);
            end else begin
                if (r_ovf[QB] || (w_q > QB'(W_MAX)))          o_w <= W_MAX;
                else                                          o_w <= OW'(w_q);
            end
        end
    end
endmodule

/* rtl/triangle_barycentric_coordinates_unit.sv */
// Barycentric weights of a point P against triangle ABC in signed fixed point.
// Input beat (i_pt): P, A, B, C, COORD_WIDTH bits each, FRAC_BITS fraction bits.
// Output beat (o_res): weight_a, weight_b, weight_c (signed 32-bit, FRAC_BITS
// fraction bits, saturated) and degenerate, set for a zero-area triangle, in
// which case the weights are (1, 0, 0).
// Throughput: one beat per cycle while o_res.ready is high. Stages from input to
// output register: 1 difference stage, 4 cross-product, 4 dot-product, 36 divider
// (setup, then one quotient bit per stage, then the result) and 1 output stage.
// Every stage has its own valid bit and advances when it is empty or when the
// stage after it advances, so bubbles close up and new beats are taken while
// a finished result waits for o_res.ready. A stalled result holds steady.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers are
// not reset. Depends on bcu_pkg, bcu_in_if, bcu_out_if, bcu_crs, bcu_dot,
// bcu_div, bcu_mul.
module triangle_barycentric_coordinates_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bcu_in_if.snk  i_pt,
    bcu_out_if.src o_res
);
    import bcu_pkg::*;

    localparam int DW    = COORD_WIDTH + 1;   // coordinate difference
    localparam int NW    = 2 * DW + 1;        // cross product component
    localparam int SW    = 2 * NW + 2;        // dot product
    localparam int S_CRS = 1;
    localparam int S_DOT = S_CRS + CRS_STAGES;
    localparam int S_DIV = S_DOT + DOT_STAGES;
    localparam int S_OUT = S_DIV + DIV_STAGES;
    localparam int NS    = S_OUT + 1;
    localparam logic signed [OW-1:0] W_ONE = OW'(1) << FRAC_BITS;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_en;

    // stage enables: a stage loads when it is empty or its beat moves on
    assign w_en[NS] = o_res.ready;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign w_en[k] = !r_v[k] || w_en[k+1];
    end
    assign i_pt.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_pt.valid;
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // differences B-A, C-A, B-P, C-P, A-P
    logic signed [DW-1:0] r_ba [3], r_ca [3], r_bp [3], r_cp [3], r_ap [3];
    logic signed [COORD_WIDTH-1:0] w_p [3], w_a [3], w_b [3], w_c [3];
    assign w_p = '{i_pt.p_x, i_pt.p_y, i_pt.p_z};
    assign w_a = '{i_pt.a_x, i_pt.a_y, i_pt.a_z};
    assign w_b = '{i_pt.b_x, i_pt.b_y, i_pt.b_z};
    assign w_c = '{i_pt.c_x, i_pt.c_y, i_pt.c_z};

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_ba[k] <= DW'(w_b[k]) - DW'(w_a[k]);
                r_ca[k] <= DW'(w_c[k]) - DW'(w_a[k]);
                r_bp[k] <= DW'(w_b[k]) - DW'(w_p[k]);
                r_cp[k] <= DW'(w_c[k]) - DW'(w_p[k]);
                r_ap[k] <= DW'(w_a[k]) - DW'(w_p[k]);
            end
        end
    end

    // N = (B-A)x(C-A), X1 = (B-P)x(C-P), X2 = (C-P)x(A-P)
    logic signed [NW-1:0] w_n [3], w_x1 [3], w_x2 [3];
    bcu_crs #(.DW(DW)) u_crs_n (
        .i_clk (i_clk), .i_en (w_en[S_CRS +: CRS_STAGES]),
        .i_u (r_ba), .i_v (r_ca), .o_r (w_n)
    );
    bcu_crs #(.DW(DW)) u_crs_x1 (
        .i_clk (i_clk), .i_en (w_en[S_CRS +: CRS_STAGES]),
        .i_u (r_bp), .i_v (r_cp), .o_r (w_x1)
    );
    bcu_crs #(.DW(DW)) u_crs_x2 (
        .i_clk (i_clk), .i_en (w_en[S_CRS +: CRS_STAGES]),
        .i_u (r_cp), .i_v (r_ap), .o_r (w_x2)
    );

    // N.N and the two numerators
    logic signed [SW-1:0] w_den, w_num_a, w_num_b;
    bcu_dot #(.NW(NW)) u_dot_den (
        .i_clk (i_clk), .i_en (w_en[S_DOT +: DOT_STAGES]),
        .i_u (w_n), .i_v (w_n), .o_s (w_den)
    );
    bcu_dot #(.NW(NW)) u_dot_a (
        .i_clk (i_clk), .i_en (w_en[S_DOT +: DOT_STAGES]),
        .i_u (w_n), .i_v (w_x1), .o_s (w_num_a)
    );
    bcu_dot #(.NW(NW)) u_dot_b (
        .i_clk (i_clk), .i_en (w_en[S_DOT +: DOT_STAGES]),
        .i_u (w_n), .i_v (w_x2), .o_s (w_num_b)
    );

    // two dividers share the denominator; the zero-area flag rides with A
    logic signed [OW-1:0] w_wa, w_wb;
    logic                 w_dz, w_dz_unused;
    bcu_div #(.SW(SW), .FRAC_BITS(FRAC_BITS)) u_div_a (
        .i_clk (i_clk), .i_en (w_en[S_DIV +: DIV_STAGES]),
        .i_num (w_num_a), .i_den (w_den), .o_w (w_wa), .o_dz (w_dz)
    );
    bcu_div #(.SW(SW), .FRAC_BITS(FRAC_BITS)) u_div_b (
        .i_clk (i_clk), .i_en (w_en[S_DIV +: DIV_STAGES]),
        .i_num (w_num_b), .i_den (w_den), .o_w (w_wb), .o_dz (w_dz_unused)
    );

    // weight_c = 1 - a - b from the saturated a and b, then clamped
    logic signed [OW+1:0] w_wc_full;
    logic signed [OW-1:0] w_wc;
    assign w_wc_full = (OW+2)'(W_ONE) - (OW+2)'(w_wa) - (OW+2)'(w_wb);
    always_comb begin
        if (w_wc_full > (OW+2)'(W_MAX))      w_wc = W_MAX;
        else if (w_wc_full < (OW+2)'(W_MIN)) w_wc = W_MIN;
        else                                 w_wc = OW'(w_wc_full);
    end

    logic signed [OW-1:0] r_wa, r_wb, r_wc;
    logic                 r_dgn;
    always_ff @(posedge i_clk) begin
        if (w_en[S_OUT]) begin
            r_dgn <= w_dz;
            r_wa  <= w_dz ? W_ONE : w_wa;
            r_wb  <= w_dz ? '0 : w_wb;
            r_wc  <= w_dz ? '0 : w_wc;
        end
    end

    assign o_res.valid      = r_v[NS-1];
    assign o_res.weight_a   = r_wa;
    assign o_res.weight_b   = r_wb;
    assign o_res.weight_c   = r_wc;
    assign o_res.degenerate = r_dgn;

`ifndef SYNTHESIS
    logic signed [OW+1:0] w_chk_sum;
    assign w_chk_sum = (OW+2)'(r_wa) + (OW+2)'(r_wb) + (OW+2)'(r_wc);

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("pipeline not empty after reset");

    a_dgn_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.degenerate |->
            o_res.weight_a == W_ONE && o_res.weight_b == '0 && o_res.weight_c == '0)
        else $error("degenerate result not (1,0,0)");

    a_sum_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.degenerate && r_wc != W_MAX && r_wc != W_MIN
            |-> w_chk_sum == (OW+2)'(W_ONE))
        else $error("weights do not sum to one");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-2] && !w_en[NS-1] |=> r_v[NS-2])
        else $error("beat lost before output stage");
`endif
endmodule
